// ===== hw/rtl/chi_pkg.sv =====
// Package: shared constants, types and helper structs for the channel hit aggregator.
`default_nettype none
package chi_pkg;

  // Storage sizes
  localparam int MAX_CHANNELS    = 2048;
  localparam int KEY_SPACE       = 16384;
  localparam int KEY_CARD_STRIDE = 100;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int CARD_W    = 8;
  localparam int CHAN_W    = 7;
  localparam int VAL_W     = 32;
  localparam int SLOT_IN_W = 11;
  localparam int COUNT_W   = 12;
  localparam int COUNT_MAX = 4095;

  // Derived widths
  localparam int SLOT_W     = $clog2(MAX_CHANNELS);
  localparam int KEY_W      = $clog2(KEY_SPACE);
  localparam int KEY_CALC_W = (KEY_W > 15) ? KEY_W : 15;
  localparam int MAP_W      = SLOT_W + 1;
  localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
  localparam int CLR_N      = (KEY_SPACE > MAX_CHANNELS) ? KEY_SPACE : MAX_CHANNELS;
  localparam int CLR_W      = $clog2(CLR_N);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_HIT  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_LOOK,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [CARD_W-1:0]    card_id;
    logic [CHAN_W-1:0]    channel_id;
    logic signed [VAL_W-1:0] hit_val;
    logic [SLOT_IN_W-1:0] slot_index;
    logic                 map_valid;
  } item_t;

  typedef struct packed {
    logic                    was_filled;
    logic signed [VAL_W-1:0] stored_value;
    logic [COUNT_W-1:0]      filled_count;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic map_wr;
    logic map_rd;
    logic slot_rd_item;
    logic slot_rd_map;
    logic hit_wr;
    logic read_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            clr_last;
    logic [OP_W-1:0] op;
    logic            key_ok;
    logic            map_hit;
    logic            out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chi_if.sv =====
// Interfaces: input item, result and configuration channels.
`default_nettype none
interface chi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [chi_pkg::OP_W-1:0]             op;
  logic [chi_pkg::CARD_W-1:0]           card_id;
  logic [chi_pkg::CHAN_W-1:0]           channel_id;
  logic signed [chi_pkg::VAL_W-1:0]     hit_val;
  logic [chi_pkg::SLOT_IN_W-1:0]        slot_index;
  logic                                 map_valid;

  modport source (output valid, op, card_id, channel_id, hit_val, slot_index, map_valid,
                  input ready);
  modport sink   (input valid, op, card_id, channel_id, hit_val, slot_index, map_valid,
                  output ready);
endinterface

interface chi_out_if;
  logic                             valid;
  logic                             ready;
  logic                             was_filled;
  logic signed [chi_pkg::VAL_W-1:0] stored_value;
  logic [chi_pkg::COUNT_W-1:0]      filled_count;

  modport source (output valid, was_filled, stored_value, filled_count, input ready);
  modport sink   (input valid, was_filled, stored_value, filled_count, output ready);
endinterface

interface chi_cfg_if;
  logic valid;
  logic ready;
  logic sum_mode;

  modport source (output valid, sum_mode, input ready);
  modport sink   (input valid, sum_mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/chi_ctrl.sv =====
// Controller: state machine sequencing clear pass, map access and slot update.
`default_nettype none
module chi_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire chi_pkg::status_t sts_i,
  output chi_pkg::cmd_t         cmd_o
);

  chi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chi_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      chi_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = chi_pkg::ST_IDLE;
        end
      end
      chi_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = chi_pkg::ST_ISSUE;
        end
      end
      chi_pkg::ST_ISSUE: begin
        state_d = chi_pkg::ST_IDLE;
        case (sts_i.op)
          chi_pkg::OP_LOAD: begin
            cmd_o.map_wr = 1'b1;
          end
          chi_pkg::OP_HIT: begin
            if (sts_i.key_ok) begin
              cmd_o.map_rd = 1'b1;
              state_d      = chi_pkg::ST_LOOK;
            end
          end
          chi_pkg::OP_READ: begin
            cmd_o.slot_rd_item = 1'b1;
            state_d            = chi_pkg::ST_MODIFY;
          end
          default: begin
            state_d = chi_pkg::ST_IDLE;
          end
        endcase
      end
      chi_pkg::ST_LOOK: begin
        if (sts_i.map_hit) begin
          cmd_o.slot_rd_map = 1'b1;
          state_d           = chi_pkg::ST_MODIFY;
        end else begin
          state_d = chi_pkg::ST_IDLE;
        end
      end
      chi_pkg::ST_MODIFY: begin
        if (sts_i.op == chi_pkg::OP_HIT) begin
          cmd_o.hit_wr = 1'b1;
          state_d      = chi_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.read_done = 1'b1;
          state_d         = chi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = chi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/chi_datapath.sv =====
// Datapath: key map and slot memories, aggregation arithmetic, counters, result register.
`default_nettype none
module chi_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire chi_pkg::cmd_t    cmd_i,
  output chi_pkg::status_t      sts_o,
  input  wire chi_pkg::item_t   item_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_sum_mode_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output chi_pkg::result_t      res_o
);

  localparam int SW  = chi_pkg::SLOT_W;
  localparam int VW  = chi_pkg::VAL_W;
  localparam int KW  = chi_pkg::KEY_W;
  localparam int KCW = chi_pkg::KEY_CALC_W;
  localparam int MW  = chi_pkg::MAP_W;
  localparam int CW  = chi_pkg::CNT_W;
  localparam int RW  = chi_pkg::CLR_W;

  chi_pkg::item_t item_q;
  logic           sum_mode_q;
  logic [RW-1:0]  clr_ctr_q;
  logic [CW-1:0]  filled_total_q;

  logic [MW-1:0]   map_mem [chi_pkg::KEY_SPACE];
  logic [MW-1:0]   map_rdata_q;
  logic [VW:0]     slot_mem [chi_pkg::MAX_CHANNELS];
  logic [VW:0]     slot_rdata_q;
  logic [SW-1:0]   slot_addr_q;

  logic              out_valid_q;
  chi_pkg::result_t  res_q;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      sum_mode_q <= cfg_sum_mode_i;
    end
  end

  // Key and range checks
  logic [KCW-1:0] key_calc;
  logic [KW-1:0]  key_idx;
  logic           key_ok;
  logic           slot_ok;
  logic [SW-1:0]  item_slot;

  assign key_calc  = KCW'(item_q.card_id) * KCW'(chi_pkg::KEY_CARD_STRIDE)
                   + KCW'(item_q.channel_id);
  assign key_idx   = key_calc[KW-1:0];
  assign key_ok    = 32'(key_calc) < 32'(chi_pkg::KEY_SPACE);
  assign slot_ok   = 32'(item_q.slot_index) < 32'(chi_pkg::MAX_CHANNELS);
  assign item_slot = SW'(item_q.slot_index);

  // Clear sweep
  logic clr_last;
  logic clr_in_map;
  logic clr_in_slot;

  assign clr_last    = clr_ctr_q == RW'(chi_pkg::CLR_N - 1);
  assign clr_in_map  = 32'(clr_ctr_q) < 32'(chi_pkg::KEY_SPACE);
  assign clr_in_slot = 32'(clr_ctr_q) < 32'(chi_pkg::MAX_CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ctr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_ctr_q <= clr_ctr_q + RW'(1);
    end
  end

  // Key map memory
  logic          map_we;
  logic [KW-1:0] map_waddr;
  logic [MW-1:0] map_wdata;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = key_idx;
    map_wdata = '0;
    if (cmd_i.clr_step) begin
      map_we    = clr_in_map;
      map_waddr = clr_ctr_q[KW-1:0];
    end else if (cmd_i.map_wr && key_ok) begin
      // unmap always; map only to an existing slot
      map_we    = !item_q.map_valid || slot_ok;
      map_wdata = item_q.map_valid ? {1'b1, item_slot} : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd_i.map_rd) begin
      map_rdata_q <= map_mem[key_idx];
    end
  end

  // Slot memory: {filled, value}
  logic          slot_rd;
  logic [SW-1:0] slot_raddr;

  assign slot_rd    = cmd_i.slot_rd_item || cmd_i.slot_rd_map;
  assign slot_raddr = cmd_i.slot_rd_item ? item_slot : map_rdata_q[SW-1:0];

  logic                 old_filled;
  logic signed [VW-1:0] old_val;
  logic signed [VW-1:0] hv;
  logic signed [VW:0]   sum_wide;
  logic signed [VW-1:0] sum_sat;
  logic signed [VW-1:0] min_val;
  logic signed [VW-1:0] new_val;
  logic                 rd_filled;

  assign old_filled = slot_rdata_q[VW];
  assign old_val    = slot_rdata_q[VW-1:0];
  assign hv         = item_q.hit_val;
  assign sum_wide   = {old_val[VW-1], old_val} + {hv[VW-1], hv};
  assign min_val    = (old_val > hv) ? hv : old_val;
  assign rd_filled  = old_filled && slot_ok;

  always_comb begin
    if (sum_wide[VW] != sum_wide[VW-1]) begin
      // clamp on overflow toward the sign of the true sum
      sum_sat = sum_wide[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[VW-1:0];
    end
    if (!old_filled) begin
      new_val = hv;
    end else if (sum_mode_q) begin
      new_val = sum_sat;
    end else begin
      new_val = min_val;
    end
  end

  logic          slot_we;
  logic [SW-1:0] slot_waddr;
  logic [VW:0]   slot_wdata;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr_q;
    slot_wdata = '0;
    if (cmd_i.clr_step) begin
      slot_we    = clr_in_slot;
      slot_waddr = clr_ctr_q[SW-1:0];
    end else if (cmd_i.hit_wr) begin
      slot_we    = 1'b1;
      slot_wdata = {1'b1, new_val};
    end else if (cmd_i.read_done) begin
      slot_we    = rd_filled;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_rd) begin
      slot_rdata_q <= slot_mem[slot_raddr];
      slot_addr_q  <= slot_raddr;
    end
  end

  // Filled slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_total_q <= '0;
    end else if (cmd_i.hit_wr && !old_filled) begin
      filled_total_q <= filled_total_q + CW'(1);
    end else if (cmd_i.read_done && rd_filled && (filled_total_q != '0)) begin
      filled_total_q <= filled_total_q - CW'(1);
    end
  end

  // Result register
  logic [chi_pkg::COUNT_W-1:0] count_sat;

  assign count_sat = (32'(filled_total_q) > 32'(chi_pkg::COUNT_MAX))
                   ? chi_pkg::COUNT_W'(chi_pkg::COUNT_MAX)
                   : chi_pkg::COUNT_W'(filled_total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.read_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_done) begin
      res_q.was_filled   <= rd_filled;
      res_q.stored_value <= rd_filled ? old_val : '0;
      res_q.filled_count <= count_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign sts_o.clr_last = clr_last;
  assign sts_o.op       = item_q.op;
  assign sts_o.key_ok   = key_ok;
  assign sts_o.map_hit  = map_rdata_q[MW-1];
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// ===== hw/rtl/channel_hit_aggregator.sv =====
// Top level: channel hit aggregator, controller plus datapath.
//
//   Channel  Dir  Handshake      Carries
//   in_i     in   valid/ready    op, card_id, channel_id, hit_val, slot_index, map_valid
//   cfg_i    in   valid/ready    sum_mode (always ready)
//   out_o    out  valid/ready    was_filled, stored_value, filled_count (read only)
//
// One transaction at a time: load and unused op go through ISSUE only; hit goes through ISSUE,
// LOOK and MODIFY (back after LOOK when unmapped, after ISSUE when the key is out of range);
// read goes through ISSUE and MODIFY. Key map and slot reads are registered. After reset a
// clearing pass over every key map and slot address empties the key map and the filled flags;
// in_i stays not ready meanwhile. A result waits in its own register; new transactions are
// taken while it stalls, and only a following read holds until the register frees up.
`default_nettype none
module channel_hit_aggregator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chi_in_if.sink     in_i,
  chi_cfg_if.sink    cfg_i,
  chi_out_if.source  out_o
);

  chi_pkg::cmd_t    cmd;
  chi_pkg::status_t sts;
  chi_pkg::item_t   item;
  chi_pkg::result_t res;
  logic             in_ready;
  logic             out_valid;

  // Pack the incoming transaction
  assign item.op         = in_i.op;
  assign item.card_id    = in_i.card_id;
  assign item.channel_id = in_i.channel_id;
  assign item.hit_val    = in_i.hit_val;
  assign item.slot_index = in_i.slot_index;
  assign item.map_valid  = in_i.map_valid;

  assign in_i.ready  = in_ready;

  // Configuration is to be written only while idle (the user's duty, unenforced here), so take it at once
  assign cfg_i.ready = 1'b1;

  chi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chi_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_i         (item),
    .cfg_we_i       (cfg_i.valid),
    .cfg_sum_mode_i (cfg_i.sum_mode),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_o.ready),
    .res_o          (res)
  );

  // Drive the result channel from the result register
  assign out_o.valid        = out_valid;
  assign out_o.was_filled   = res.was_filled;
  assign out_o.stored_value = res.stored_value;
  assign out_o.filled_count = res.filled_count;

endmodule
`default_nettype wire

// ===== hw/rtl/chi_checker.sv =====
// Checker: port-level assertions for the channel hit aggregator, with its bind.
`default_nettype none
module chi_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire logic                             out_was_filled_i,
  input wire logic signed [chi_pkg::VAL_W-1:0] out_stored_value_i,
  input wire logic [chi_pkg::COUNT_W-1:0]      out_filled_count_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_stored_value_i))
    else $error("result dropped or changed while stalled");

  // One transaction in flight: never ready right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transaction taken while busy");

  // Empty slot reads back as zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_was_filled_i |-> out_stored_value_i == '0)
    else $error("empty slot returned nonzero value");

  // Count never exceeds the number of slots
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> 32'(out_filled_count_i) <= 32'(chi_pkg::MAX_CHANNELS))
    else $error("filled count beyond slot count");

  // A filled slot read leaves a count of at least one
  a_count_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_was_filled_i |-> out_filled_count_i != '0)
    else $error("filled slot reported with zero count");

endmodule

bind channel_hit_aggregator chi_checker u_chi_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_was_filled_i   (out_o.was_filled),
  .out_stored_value_i (out_o.stored_value),
  .out_filled_count_i (out_o.filled_count)
);
`default_nettype wire
